[src/flash_eeprom_append_allocator_macros.svh]
// assertion macros for the flash eeprom append allocator
// every macro expects i_clk and i_rst_n in the enclosing scope
`ifndef FLASH_EEPROM_APPEND_ALLOCATOR_MACROS_SVH
`define FLASH_EEPROM_APPEND_ALLOCATOR_MACROS_SVH

// same-cycle implication
`define FEAA_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("allocator check failed");

// next-cycle implication
`define FEAA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("allocator check failed");

`endif

[src/feaa_pkg.sv]
// ----------------------------------------------------------------------------
// feaa_pkg
// Shared types and codes for the flash eeprom append allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package feaa_pkg;

    // field widths
    localparam int LEN_W   = 16;
    localparam int ALIGN_W = 13;
    localparam int SIZE_W  = 25;
    localparam int WORD_W  = 32;
    localparam int CFG_IDX_W = 3;

    // action codes
    localparam logic [1:0] ACT_MOUNT = 2'd0;
    localparam logic [1:0] ACT_PROBE = 2'd1;
    localparam logic [1:0] ACT_WRITE = 2'd2;

    // status codes
    localparam logic [1:0] STS_OK          = 2'd0;
    localparam logic [1:0] STS_NOT_MOUNTED = 2'd1;
    localparam logic [1:0] STS_INVALID     = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BASE0     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE0     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE1     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE1     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SEC_COUNT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ALIGN     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESH    = 3'd6;

    // input transaction
    typedef struct packed {
        logic [1:0]       action;
        logic             head0_has_data;
        logic             head1_has_data;
        logic             probe_blank;
        logic [LEN_W-1:0] write_length;
    } t_in_item;

    // output transaction
    typedef struct packed {
        logic [1:0]        status;
        logic [WORD_W-1:0] record_address;
        logic              erase_request;
        logic              erase_sector;
        logic [WORD_W-1:0] probe_address;
        logic              mounted;
        logic              active_sector;
        logic [SIZE_W-1:0] usage_bytes;
        logic              sector_full;
        logic [WORD_W-1:0] write_count;
        logic [WORD_W-1:0] swap_count;
    } t_out_item;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic div_start;
        logic eval;
        logic commit;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic write_ok;
        logic div_done;
        logic out_free;
    } t_dp_sts;

endpackage

`default_nettype wire

[src/feaa_rem_div.sv]
// ----------------------------------------------------------------------------
// feaa_rem_div
// Restoring bit-serial divider that returns the remainder of length / align,
// one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module feaa_rem_div (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [feaa_pkg::LEN_W-1:0]    i_dividend,
    input  wire logic [feaa_pkg::ALIGN_W-1:0]  i_divisor,
    output logic                               o_done,
    output logic [feaa_pkg::ALIGN_W-1:0]       o_remainder
);
    import feaa_pkg::*;

    localparam int CNT_W = $clog2(LEN_W);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(LEN_W - 1);

    logic [ALIGN_W:0]   r_rem;
    logic [LEN_W-1:0]   r_dvd;
    logic [ALIGN_W-1:0] r_dvs;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_busy;
    logic               r_done;
    logic [ALIGN_W:0]   trial;

    // shift in next dividend bit
    assign trial = {r_rem[ALIGN_W-1:0], r_dvd[LEN_W-1]};

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == LAST_STEP) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // remainder datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_dvd <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[LEN_W-2:0], 1'b0};
            if (trial >= {1'b0, r_dvs}) begin
                r_rem <= trial - {1'b0, r_dvs};
            end else begin
                r_rem <= trial;
            end
        end
    end

    assign o_done      = r_done;
    assign o_remainder = r_rem[ALIGN_W-1:0];

endmodule

`default_nettype wire

[src/feaa_ctrl.sv]
// ----------------------------------------------------------------------------
// feaa_ctrl
// Sequencer: accepts one transaction, runs the rounding divide for writes,
// evaluates the swap decision and commits when the output slot is free.
// ----------------------------------------------------------------------------
`default_nettype none

module feaa_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire feaa_pkg::t_dp_sts  i_sts,
    output feaa_pkg::t_dp_cmd       o_cmd
);
    import feaa_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_EVAL = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       accept;

    assign accept     = (r_state == S_IDLE) && i_in_valid;
    assign o_in_stall = (r_state != S_IDLE);

    // next state and commands
    always_comb begin
        n_state         = r_state;
        o_cmd           = '0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_cmd.capture = 1'b1;
                    if (i_sts.write_ok) begin
                        o_cmd.div_start = 1'b1;
                        n_state         = S_DIV;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_DIV: begin
                if (i_sts.div_done) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                o_cmd.eval = 1'b1;
                n_state    = S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

[src/feaa_datapath.sv]
// ----------------------------------------------------------------------------
// feaa_datapath
// Configuration registers, allocator state, rounding divider and the
// output register of the flash eeprom append allocator.
// ----------------------------------------------------------------------------
`default_nettype none

module feaa_datapath #(
    parameter int ADDR_WIDTH = 32
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [feaa_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [feaa_pkg::WORD_W-1:0]     i_cfg_wdata,
    input  wire feaa_pkg::t_in_item              i_in_data,
    input  wire logic                            i_out_stall,
    output logic                                 o_out_valid,
    output feaa_pkg::t_out_item                  o_out_data,
    input  wire feaa_pkg::t_dp_cmd               i_cmd,
    output feaa_pkg::t_dp_sts                    o_sts
);
    import feaa_pkg::*;

    localparam int AW = ADDR_WIDTH;

    // configuration
    logic [AW-1:0]      r_base0, r_base1;
    logic [SIZE_W-1:0]  r_size0, r_size1, r_thresh;
    logic [1:0]         r_sec_count;
    logic [ALIGN_W-1:0] r_align;

    // allocator state
    logic               r_active;
    logic [AW-1:0]      r_wpos, r_spos;
    logic [SIZE_W-1:0]  r_used;
    logic               r_scanning, r_ready;
    logic [WORD_W-1:0]  r_writes, r_swaps;

    // captured transaction and write evaluation
    t_in_item           r_item;
    logic [LEN_W:0]     r_aligned;
    logic               r_swap, r_reject;

    // output register
    logic               r_out_valid;
    t_out_item          r_out;

    logic [ALIGN_W-1:0] step;
    logic               div_done;
    logic [ALIGN_W-1:0] div_rem;
    logic               out_free;

    // next state values
    logic               n_active;
    logic [AW-1:0]      n_wpos, n_spos;
    logic [SIZE_W-1:0]  n_used;
    logic               n_scanning, n_ready;
    logic [WORD_W-1:0]  n_writes, n_swaps;
    t_out_item          n_out;

    // combinational helpers
    logic               mnt_active;
    logic [AW-1:0]      mnt_base, cur_base, tgt_base, wr_pos;
    logic [SIZE_W-1:0]  mnt_size, cur_size, tgt_size, wr_used;
    logic [SIZE_W:0]    probe_next, fit_sum;
    logic               ev_swap, ev_target;

    // zero alignment steps by one
    assign step = (r_align == '0) ? ALIGN_W'(1) : r_align;

    assign out_free       = !r_out_valid || !i_out_stall;
    assign o_sts.out_free = out_free;
    assign o_sts.div_done = div_done;
    assign o_sts.write_ok = (i_in_data.action == ACT_WRITE) && r_ready
                            && (i_in_data.write_length != '0);

    // remainder of length by alignment
    feaa_rem_div u_rem_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_cmd.div_start),
        .i_dividend  (i_in_data.write_length),
        .i_divisor   (step),
        .o_done      (div_done),
        .o_remainder (div_rem)
    );

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base0     <= '0;
            r_size0     <= SIZE_W'(4096);
            r_base1     <= AW'(4096);
            r_size1     <= SIZE_W'(4096);
            r_sec_count <= 2'd2;
            r_align     <= ALIGN_W'(8);
            r_thresh    <= SIZE_W'(4096);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_BASE0:     r_base0     <= i_cfg_wdata[AW-1:0];
                CFG_SIZE0:     r_size0     <= i_cfg_wdata[SIZE_W-1:0];
                CFG_BASE1:     r_base1     <= i_cfg_wdata[AW-1:0];
                CFG_SIZE1:     r_size1     <= i_cfg_wdata[SIZE_W-1:0];
                CFG_SEC_COUNT: r_sec_count <= i_cfg_wdata[1:0];
                CFG_ALIGN:     r_align     <= i_cfg_wdata[ALIGN_W-1:0];
                CFG_THRESH:    r_thresh    <= i_cfg_wdata[SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    // capture, rounding and swap evaluation
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_item <= i_in_data;
        end
        if (div_done) begin
            r_aligned <= {1'b0, r_item.write_length}
                         + ((div_rem != '0) ? (LEN_W+1)'(step - div_rem) : '0);
        end
        if (i_cmd.eval) begin
            r_swap   <= ev_swap;
            r_reject <= ev_swap && ((r_sec_count < 2'd2)
                        || ({{(SIZE_W-LEN_W-1){1'b0}}, r_aligned} > tgt_size));
        end
    end

    // sector selection
    always_comb begin
        cur_base   = r_active ? r_base1 : r_base0;
        cur_size   = r_active ? r_size1 : r_size0;
        mnt_active = (r_sec_count >= 2'd2) && !r_item.head0_has_data
                     && r_item.head1_has_data;
        mnt_base   = mnt_active ? r_base1 : r_base0;
        mnt_size   = mnt_active ? r_size1 : r_size0;
        fit_sum    = {1'b0, r_used} + (SIZE_W+1)'(r_aligned);
        ev_swap    = (fit_sum > {1'b0, cur_size}) || (r_used >= r_thresh);
        ev_target  = r_active ^ ev_swap;
        tgt_base   = ev_target ? r_base1 : r_base0;
        tgt_size   = ev_target ? r_size1 : r_size0;
        probe_next = {1'b0, r_used} + (SIZE_W+1)'(step);
        wr_pos     = r_swap ? tgt_base : r_wpos;
        wr_used    = r_swap ? '0 : r_used;
    end

    // next state on commit
    always_comb begin
        n_active   = r_active;
        n_wpos     = r_wpos;
        n_spos     = r_spos;
        n_used     = r_used;
        n_scanning = r_scanning;
        n_ready    = r_ready;
        n_writes   = r_writes;
        n_swaps    = r_swaps;
        n_out      = '0;
        n_out.status = STS_OK;
        unique case (r_item.action)
            ACT_MOUNT: begin
                if (r_sec_count == 2'd0) begin
                    n_out.status = STS_INVALID;
                    n_scanning   = 1'b0;
                    n_ready      = 1'b0;
                end else if (mnt_size == '0) begin
                    // empty sector mounts full at its base
                    n_active   = mnt_active;
                    n_spos     = mnt_base;
                    n_wpos     = mnt_base;
                    n_used     = '0;
                    n_scanning = 1'b0;
                    n_ready    = 1'b1;
                end else begin
                    n_active   = mnt_active;
                    n_spos     = mnt_base;
                    n_used     = '0;
                    n_scanning = 1'b1;
                    n_ready    = 1'b0;
                end
            end
            ACT_PROBE: begin
                if (!r_scanning) begin
                    n_out.status = STS_INVALID;
                end else if (r_item.probe_blank) begin
                    n_wpos     = r_spos;
                    n_scanning = 1'b0;
                    n_ready    = 1'b1;
                end else if (probe_next >= {1'b0, cur_size}) begin
                    // scan ran off the sector end
                    n_wpos     = cur_base + AW'(cur_size);
                    n_used     = cur_size;
                    n_scanning = 1'b0;
                    n_ready    = 1'b1;
                end else begin
                    n_used = probe_next[SIZE_W-1:0];
                    n_spos = r_spos + AW'(step);
                end
            end
            ACT_WRITE: begin
                if (!r_ready) begin
                    n_out.status = STS_NOT_MOUNTED;
                end else if (r_item.write_length == '0) begin
                    n_out.status = STS_INVALID;
                end else if (r_reject) begin
                    n_out.status = STS_INVALID;
                end else begin
                    if (r_swap) begin
                        n_out.erase_request = 1'b1;
                        n_out.erase_sector  = ~r_active;
                        n_active            = ~r_active;
                        n_swaps             = r_swaps + 1'b1;
                    end
                    n_out.record_address = WORD_W'(wr_pos);
                    n_wpos   = wr_pos + AW'(r_aligned);
                    n_used   = wr_used + SIZE_W'(r_aligned);
                    n_writes = r_writes + 1'b1;
                end
            end
            default: n_out.status = STS_INVALID;
        endcase
        n_out.probe_address = n_scanning ? WORD_W'(n_spos) : '0;
        n_out.mounted       = n_ready;
        n_out.active_sector = n_active;
        n_out.usage_bytes   = n_used;
        n_out.sector_full   = n_ready && (n_used >= r_thresh);
        n_out.write_count   = n_writes;
        n_out.swap_count    = n_swaps;
    end

    // allocator state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active   <= 1'b0;
            r_wpos     <= '0;
            r_spos     <= '0;
            r_used     <= '0;
            r_scanning <= 1'b0;
            r_ready    <= 1'b0;
            r_writes   <= '0;
            r_swaps    <= '0;
        end else if (i_cmd.commit) begin
            r_active   <= n_active;
            r_wpos     <= n_wpos;
            r_spos     <= n_spos;
            r_used     <= n_used;
            r_scanning <= n_scanning;
            r_ready    <= n_ready;
            r_writes   <= n_writes;
            r_swaps    <= n_swaps;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

[src/flash_eeprom_append_allocator.sv]
// Sequence: mount, probe and rejected transactions go from acceptance to the
//   done state and commit once the output slot is free; a write that is placed
//   or checked for room first passes the divide and evaluate states.
// Flow: one transaction at a time; the 16-step remainder divider rounds writes.
// Reset: synchronous active-low; registers return to defaults, state clears.
// ----------------------------------------------------------------------------
// flash_eeprom_append_allocator
// Append-only write allocator for a two-sector flash eeprom emulation:
// mount, head scan and aligned record placement with sector swap.
// ----------------------------------------------------------------------------
`default_nettype none

module flash_eeprom_append_allocator #(
    parameter int ADDR_WIDTH = 32
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [feaa_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [feaa_pkg::WORD_W-1:0]     i_cfg_wdata,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_stall,
    input  wire feaa_pkg::t_in_item              i_in_data,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_stall,
    output feaa_pkg::t_out_item                  o_out_data
);
    import feaa_pkg::*;

`include "flash_eeprom_append_allocator_macros.svh"

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    // sequencer
    feaa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (dp_sts),
        .o_cmd      (dp_cmd)
    );

    // allocator datapath
    feaa_datapath #(
        .ADDR_WIDTH (ADDR_WIDTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_data   (i_in_data),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_cmd       (dp_cmd),
        .o_sts       (dp_sts)
    );

    // checks
    `FEAA_ASSERT_NEXT(a_one_in_flight, i_in_valid && !o_in_stall, o_in_stall)
    `FEAA_ASSERT_IMPL(a_commit_slot_free, dp_cmd.commit, dp_sts.out_free)
    `FEAA_ASSERT_IMPL(a_div_while_busy, dp_sts.div_done, o_in_stall)
    `FEAA_ASSERT_IMPL(a_erase_only_ok, o_out_valid && o_out_data.erase_request,
                      o_out_data.status == STS_OK)

endmodule

`default_nettype wire

[tb/sv/tb_flash_eeprom_append_allocator.sv]
// ----------------------------------------------------------------------------
// tb_flash_eeprom_append_allocator
// Self-checking bench for the flash eeprom append allocator. A directed
// table walks reset behavior, mount, scan and write corner cases. Random
// phases then run mount/scan/write sequences mixed with noise under several
// register settings and handshake idling patterns. Every accepted response
// is checked field by field against an in-bench allocator model or a typed row.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_flash_eeprom_append_allocator;

    import feaa_pkg::*;

    localparam int         RESET_CYCLES = 6;
    localparam int         DRAIN_CYCLES = 30;
    localparam int         LIMIT_CYCLES = 400000;
    localparam int         DIR_ROWS     = 23;
    localparam logic [1:0] ACT_UNUSED   = 2'd3;

    // one stimulus row: transaction plus optional hand-typed response
    typedef struct packed {
        t_in_item  item;
        logic      typed;
        t_out_item want;
    } t_stim_row;

    // clock, reset and block ports
    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [WORD_W-1:0]    cfg_wdata = '0;
    logic                 in_valid  = 1'b0;
    logic                 in_stall;
    t_stim_row            cur_row   = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    t_out_item            out_data;

    // stimulus and expected responses
    t_stim_row stim_q[$];
    t_out_item alloc_resp_q[$];
    int        src_gap_pct    = 0;
    int        sink_stall_pct = 0;
    int        n_errors       = 0;
    int        cycle_cnt      = 0;

    // mirrored registers, reset values
    logic [31:0] set_base [2] = '{32'd0, 32'd4096};
    logic [24:0] set_size [2] = '{25'd4096, 25'd4096};
    logic [1:0]  set_count    = 2'd2;
    logic [12:0] set_align    = 13'd8;
    logic [24:0] set_thresh   = 25'd4096;

    // allocator model state
    logic        alloc_active   = 1'b0;
    logic [31:0] alloc_wr_pos   = '0;
    logic [24:0] alloc_used     = '0;
    logic [31:0] alloc_scan_pos = '0;
    logic        alloc_scanning = 1'b0;
    logic        alloc_ready    = 1'b0;
    logic [31:0] alloc_writes   = '0;
    logic [31:0] alloc_swaps    = '0;

    flash_eeprom_append_allocator dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_wdata (cfg_wdata),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (cur_row.item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    // clock
    initial begin
        forever #5 clk = ~clk;
    end

    function automatic t_in_item mk_in(input logic [1:0] act, input logic h0, input logic h1,
                                       input logic blank, input logic [LEN_W-1:0] len);
        mk_in = '{act, h0, h1, blank, len};
    endfunction

    function automatic t_out_item exp_out(input logic [1:0] sts, input logic [31:0] phys,
                                          input logic ereq, input logic esec,
                                          input logic [31:0] probe, input logic mnt,
                                          input logic act, input logic [24:0] usage,
                                          input logic full, input logic [31:0] wcnt,
                                          input logic [31:0] scnt);
        exp_out = '{sts, phys, ereq, esec, probe, mnt, act, usage, full, wcnt, scnt};
    endfunction

    function automatic t_stim_row typed_row(input t_in_item it, input t_out_item w);
        typed_row = '{it, 1'b1, w};
    endfunction

    function automatic t_stim_row open_row(input t_in_item it);
        open_row = '{it, 1'b0, '0};
    endfunction

    // record length: mostly small, some full range and extremes
    function automatic logic [LEN_W-1:0] rec_len();
        case ($urandom_range(9))
            0:          rec_len = LEN_W'($urandom);
            1:          rec_len = ($urandom_range(1) == 0) ? 16'hFFFF : 16'd0;
            2, 3, 4, 5: rec_len = LEN_W'($urandom_range(1, 64));
            6, 7, 8:    rec_len = LEN_W'($urandom_range(1, 512));
            default:    rec_len = LEN_W'($urandom_range(1, 4096));
        endcase
    endfunction

    // scan reached the sector end: position at base plus size, sector full
    task automatic close_scan_at_end();
        alloc_wr_pos   = set_base[alloc_active] + 32'(set_size[alloc_active]);
        alloc_used     = set_size[alloc_active];
        alloc_scanning = 1'b0;
        alloc_ready    = 1'b1;
    endtask

    // allocator model: apply one transaction, return the response
    task automatic place_record(input t_in_item it, output t_out_item res);
        logic [31:0] step;
        logic [31:0] nxt;
        logic [31:0] aligned;
        logic [31:0] sz;
        logic [31:0] room;
        logic        swap;
        logic        tgt;
        res        = '0;
        res.status = STS_OK;
        step       = (set_align == '0) ? 32'd1 : 32'(set_align);
        if (it.action == ACT_MOUNT) begin
            if (set_count == 2'd0) begin
                res.status     = STS_INVALID;
                alloc_scanning = 1'b0;
                alloc_ready    = 1'b0;
            end else begin
                alloc_active   = (set_count >= 2'd2) && !it.head0_has_data
                                 && it.head1_has_data;
                alloc_scan_pos = set_base[alloc_active];
                alloc_used     = '0;
                alloc_scanning = 1'b1;
                alloc_ready    = 1'b0;
                if (set_size[alloc_active] == '0) close_scan_at_end();
            end
        end else if (it.action == ACT_PROBE) begin
            if (!alloc_scanning) begin
                res.status = STS_INVALID;
            end else if (it.probe_blank) begin
                alloc_wr_pos   = alloc_scan_pos;
                alloc_scanning = 1'b0;
                alloc_ready    = 1'b1;
            end else begin
                nxt = 32'(alloc_used) + step;
                if (nxt >= 32'(set_size[alloc_active])) begin
                    close_scan_at_end();
                end else begin
                    alloc_used     = nxt[24:0];
                    alloc_scan_pos = alloc_scan_pos + step;
                end
            end
        end else if (it.action == ACT_WRITE) begin
            if (!alloc_ready) begin
                res.status = STS_NOT_MOUNTED;
            end else if (it.write_length == '0) begin
                res.status = STS_INVALID;
            end else begin
                aligned = ((32'(it.write_length) + step - 32'd1) / step) * step;
                sz      = 32'(set_size[alloc_active]);
                room    = (32'(alloc_used) <= sz) ? sz - 32'(alloc_used) : 32'd0;
                swap    = (room < aligned) || (alloc_used >= set_thresh);
                tgt     = alloc_active ^ swap;
                if (swap && set_count < 2'd2) begin
                    res.status = STS_INVALID;
                end else if (swap && aligned > 32'(set_size[tgt])) begin
                    res.status = STS_INVALID;
                end else begin
                    // swap: erase the other sector and restart at its base
                    if (swap) begin
                        res.erase_request = 1'b1;
                        res.erase_sector  = tgt;
                        alloc_active      = tgt;
                        alloc_wr_pos      = set_base[tgt];
                        alloc_used        = '0;
                        alloc_swaps       = alloc_swaps + 32'd1;
                    end
                    res.record_address = alloc_wr_pos;
                    alloc_wr_pos       = alloc_wr_pos + aligned;
                    alloc_used         = alloc_used + aligned[24:0];
                    alloc_writes       = alloc_writes + 32'd1;
                end
            end
        end else begin
            res.status = STS_INVALID;
        end
        res.probe_address = alloc_scanning ? alloc_scan_pos : '0;
        res.mounted       = alloc_ready;
        res.active_sector = alloc_active;
        res.usage_bytes   = alloc_used;
        res.sector_full   = alloc_ready && (alloc_used >= set_thresh);
        res.write_count   = alloc_writes;
        res.swap_count    = alloc_swaps;
    endtask

    task automatic check_field(input string tag, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            n_errors++;
            $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h",
                     $time, tag, want, got);
        end
    endtask

    task automatic check_result(input t_out_item got);
        t_out_item want;
        if (alloc_resp_q.size() == 0) begin
            n_errors++;
            $display("%0t: response with nothing pending: actual 0x%0h", $time, got);
        end else begin
            want = alloc_resp_q.pop_front();
            check_field("status", 32'(want.status), 32'(got.status));
            check_field("record_address", want.record_address, got.record_address);
            check_field("erase_request", 32'(want.erase_request), 32'(got.erase_request));
            check_field("erase_sector", 32'(want.erase_sector), 32'(got.erase_sector));
            check_field("probe_address", want.probe_address, got.probe_address);
            check_field("mounted", 32'(want.mounted), 32'(got.mounted));
            check_field("active_sector", 32'(want.active_sector), 32'(got.active_sector));
            check_field("usage_bytes", 32'(want.usage_bytes), 32'(got.usage_bytes));
            check_field("sector_full", 32'(want.sector_full), 32'(got.sector_full));
            check_field("write_count", want.write_count, got.write_count);
            check_field("swap_count", want.swap_count, got.swap_count);
        end
    endtask

    // request side: present queued transactions with random gaps
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || !in_stall) begin
            if (stim_q.size() != 0 && $urandom_range(99) >= src_gap_pct) begin
                in_valid <= 1'b1;
                cur_row  <= stim_q.pop_front();
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // response side: random stall
    always @(posedge clk) begin
        out_stall <= ($urandom_range(99) < sink_stall_pct);
    end

    // monitor: check responses, predict accepted transactions
    always @(posedge clk) begin
        t_out_item pred;
        if (rst_n) begin
            if (out_valid && !out_stall) check_result(out_data);
            if (in_valid && !in_stall) begin
                place_record(cur_row.item, pred);
                alloc_resp_q.push_back(cur_row.typed ? cur_row.want : pred);
            end
        end
    end

    // run limit
    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == LIMIT_CYCLES) begin
            $display("tb_flash_eeprom_append_allocator: done, errors");
            $finish;
        end
    end

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            CFG_BASE0:     set_base[0] = val;
            CFG_SIZE0:     set_size[0] = val[24:0];
            CFG_BASE1:     set_base[1] = val;
            CFG_SIZE1:     set_size[1] = val[24:0];
            CFG_SEC_COUNT: set_count   = val[1:0];
            CFG_ALIGN:     set_align   = val[12:0];
            CFG_THRESH:    set_thresh  = val[24:0];
            default: ;
        endcase
    endtask

    // wait until every transaction is answered, then let the block settle
    task automatic wait_drain();
        while (stim_q.size() != 0 || in_valid || alloc_resp_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // mostly mount/scan/write sequences with random content, some noise
    task automatic queue_random(input int n_items);
        int          queued;
        int          k;
        logic [31:0] bits;
        queued = 0;
        while (queued < n_items) begin
            bits = $urandom;
            if ($urandom_range(99) < 15) begin
                stim_q.push_back(open_row(bits[$bits(t_in_item)-1:0]));
                queued++;
            end else begin
                if ($urandom_range(99) < 70) begin
                    stim_q.push_back(open_row(mk_in(ACT_MOUNT, bits[0], bits[1], bits[2],
                                                    bits[18:3])));
                    k = ($urandom_range(7) == 0) ? $urandom_range(60) : $urandom_range(4);
                    repeat (k)
                        stim_q.push_back(open_row(mk_in(ACT_PROBE, bits[19], bits[20], 1'b0,
                                                        LEN_W'($urandom))));
                    stim_q.push_back(open_row(mk_in(ACT_PROBE, bits[21], bits[22], 1'b1,
                                                    LEN_W'($urandom))));
                    queued += k + 2;
                end
                k = $urandom_range(1, 12);
                repeat (k)
                    stim_q.push_back(open_row(mk_in(ACT_WRITE, bits[23], bits[24], bits[25],
                                                    rec_len())));
                queued += k;
            end
        end
    endtask

    task automatic run_phase(input logic [31:0] base0, input logic [31:0] size0,
                             input logic [31:0] base1, input logic [31:0] size1,
                             input logic [31:0] count, input logic [31:0] align,
                             input logic [31:0] thresh, input int gap_pct,
                             input int stall_pct, input int n_items);
        cfg_write(CFG_BASE0, base0);
        cfg_write(CFG_SIZE0, size0);
        cfg_write(CFG_BASE1, base1);
        cfg_write(CFG_SIZE1, size1);
        cfg_write(CFG_SEC_COUNT, count);
        cfg_write(CFG_ALIGN, align);
        cfg_write(CFG_THRESH, thresh);
        @(posedge clk);
        cfg_we         <= 1'b0;
        src_gap_pct    = gap_pct;
        sink_stall_pct = stall_pct;
        queue_random(n_items);
        wait_drain();
    endtask

    // main sequence
    initial begin
        t_stim_row dir_rows [DIR_ROWS];

        // reset values: two 4 KiB sectors at 0 and 4096, 8-byte granule
        dir_rows[0]  = typed_row(mk_in(ACT_WRITE, 1'b0, 1'b0, 1'b0, 16'd16),
                                 exp_out(STS_NOT_MOUNTED, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        dir_rows[1]  = typed_row(mk_in(ACT_PROBE, 1'b0, 1'b0, 1'b1, 16'd0),
                                 exp_out(STS_INVALID, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        dir_rows[2]  = typed_row(mk_in(ACT_UNUSED, 1'b1, 1'b1, 1'b1, 16'hFFFF),
                                 exp_out(STS_INVALID, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        dir_rows[3]  = typed_row(mk_in(ACT_MOUNT, 1'b0, 1'b0, 1'b0, 16'd0),
                                 exp_out(STS_OK, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        dir_rows[4]  = typed_row(mk_in(ACT_PROBE, 1'b0, 1'b0, 1'b0, 16'd0),
                                 exp_out(STS_OK, 0, 0, 0, 8, 0, 0, 8, 0, 0, 0));
        dir_rows[5]  = typed_row(mk_in(ACT_PROBE, 1'b0, 1'b0, 1'b1, 16'd0),
                                 exp_out(STS_OK, 0, 0, 0, 0, 1, 0, 8, 0, 0, 0));
        dir_rows[6]  = typed_row(mk_in(ACT_WRITE, 1'b0, 1'b0, 1'b0, 16'd0),
                                 exp_out(STS_INVALID, 0, 0, 0, 0, 1, 0, 8, 0, 0, 0));
        dir_rows[7]  = typed_row(mk_in(ACT_WRITE, 1'b0, 1'b0, 1'b0, 16'd1),
                                 exp_out(STS_OK, 8, 0, 0, 0, 1, 0, 16, 0, 1, 0));
        // longest record fits neither sector
        dir_rows[8]  = typed_row(mk_in(ACT_WRITE, 1'b0, 1'b0, 1'b0, 16'hFFFF),
                                 exp_out(STS_INVALID, 0, 0, 0, 0, 1, 0, 16, 0, 1, 0));
        // fill sector 0 exactly up to the threshold
        dir_rows[9]  = typed_row(mk_in(ACT_WRITE, 1'b0, 1'b0, 1'b0, 16'd4080),
                                 exp_out(STS_OK, 16, 0, 0, 0, 1, 0, 4096, 1, 2, 0));
        // full sector swaps to sector 1
        dir_rows[10] = typed_row(mk_in(ACT_WRITE, 1'b0, 1'b0, 1'b0, 16'd8),
                                 exp_out(STS_OK, 4096, 1, 1, 0, 1, 1, 8, 0, 3, 1));
        // remount keeps counters
        dir_rows[11] = typed_row(mk_in(ACT_MOUNT, 1'b1, 1'b1, 1'b0, 16'd0),
                                 exp_out(STS_OK, 0, 0, 0, 0, 0, 0, 0, 0, 3, 1));
        dir_rows[12] = typed_row(mk_in(ACT_MOUNT, 1'b0, 1'b1, 1'b0, 16'd0),
                                 exp_out(STS_OK, 0, 0, 0, 4096, 0, 1, 0, 0, 3, 1));
        dir_rows[13] = open_row(mk_in(ACT_PROBE, 1'b0, 1'b0, 1'b0, 16'd0));
        dir_rows[14] = open_row(mk_in(ACT_PROBE, 1'b1, 1'b1, 1'b0, 16'hFFFF));
        dir_rows[15] = open_row(mk_in(ACT_PROBE, 1'b0, 1'b0, 1'b1, 16'd0));
        dir_rows[16] = open_row(mk_in(ACT_WRITE, 1'b0, 1'b0, 1'b0, 16'hFFFF));
        dir_rows[17] = open_row(mk_in(ACT_WRITE, 1'b0, 1'b0, 1'b0, 16'd100));
        dir_rows[18] = open_row(mk_in(ACT_WRITE, 1'b1, 1'b1, 1'b1, 16'd4096));
        dir_rows[19] = open_row(mk_in(ACT_MOUNT, 1'b1, 1'b0, 1'b0, 16'd0));
        dir_rows[20] = open_row(mk_in(ACT_PROBE, 1'b0, 1'b0, 1'b1, 16'd0));
        dir_rows[21] = open_row(mk_in(ACT_WRITE, 1'b0, 1'b0, 1'b0, 16'h8000));
        dir_rows[22] = open_row(mk_in(ACT_WRITE, 1'b0, 1'b0, 1'b0, 16'd7));

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // directed table
        foreach (dir_rows[r]) stim_q.push_back(dir_rows[r]);
        wait_drain();

        // random phases: sizes, bases, granule and threshold extremes
        run_phase(32'h0, 4096, 32'h1000, 4096, 2, 8, 2048, 0, 0, 150);
        run_phase(32'hFFFF_F000, 64, 32'hFFFF_FFF8, 16777216, 2, 1, 16777216, 59, 0, 150);
        // tiny sector 1 shrinks below the usage left by the last phase
        run_phase(32'h0, 16777216, 32'h8000_0000, 1, 3, 4096, 0, 0, 59, 150);
        // single sector, zero granule acts as one byte
        run_phase(32'h0001_0000, 256, 32'h0002_0000, 256, 1, 0, 200, 38, 38, 150);
        // no sectors in use
        run_phase(32'h0, 4096, 32'h1000, 4096, 0, 8, 4096, 59, 0, 60);
        // empty sector 0 mounts full at once
        run_phase(32'h1000, 0, 32'h2000, 128, 2, 16, 100, 0, 0, 150);
        run_phase(32'h40, 96, 32'h400, 160, 2, 3, 120, 0, 59, 150);
        run_phase($urandom, 4096, $urandom, 4096, 2, 8, 4096, 38, 38, 150);

        if (alloc_resp_q.size() != 0) begin
            n_errors++;
            $display("%0t: %0d responses never arrived", $time, alloc_resp_q.size());
        end
        if (n_errors == 0) begin
            $display("tb_flash_eeprom_append_allocator: done, clean");
        end else begin
            $display("tb_flash_eeprom_append_allocator: done, errors");
        end
        $finish;
    end

endmodule

`default_nettype wire
